/* rtl/awsc_pkg.sv */
// ----------------------------------------------------------------------------
// Audio window sound classifier package
// Shared types and constants: register map, register reset values, the
// configuration bundle and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

package awsc_pkg;

	// Fixed field widths.
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 16;
	localparam int RMS_W    = 16;
	localparam int PEAK_W   = 23;
	localparam int MEAN_W   = 31;   // a mean of Q15 squares never exceeds 2^30
	localparam int ADDR_W   = 5;
	localparam int IDX_W    = 3;

	// Peak change is reported in hundredths.
	localparam logic [PEAK_W-1:0] PEAK_SCALE = 23'd100;

	// Register indexes (byte address is four times the index).
	localparam logic [IDX_W-1:0] REG_CRY_RMS_LOW     = 3'd0;
	localparam logic [IDX_W-1:0] REG_CRY_RMS_HIGH    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SCREAM_RMS_HIGH = 3'd2;
	localparam logic [IDX_W-1:0] REG_JUMP_THRESHOLD  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CRY_RATIO       = 3'd4;
	localparam logic [IDX_W-1:0] REG_VOICE_RMS_LOW   = 3'd5;
	localparam logic [IDX_W-1:0] REG_VOICE_RMS_HIGH  = 3'd6;

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_CRY_RMS_LOW     = 16'd22938;
	localparam logic [CFG_W-1:0] RST_CRY_RMS_HIGH    = 16'd29491;
	localparam logic [CFG_W-1:0] RST_SCREAM_RMS_HIGH = 16'd32768;
	localparam logic [CFG_W-1:0] RST_JUMP_THRESHOLD  = 16'd22938;
	localparam logic [CFG_W-1:0] RST_CRY_RATIO       = 16'd13107;
	localparam logic [CFG_W-1:0] RST_VOICE_RMS_LOW   = 16'd9830;
	localparam logic [CFG_W-1:0] RST_VOICE_RMS_HIGH  = 16'd24576;

	// Configuration bundle handed from the register file to the datapath.
	typedef struct packed {
		logic [CFG_W-1:0] cry_rms_low;
		logic [CFG_W-1:0] cry_rms_high;
		logic [CFG_W-1:0] scream_rms_high;
		logic [CFG_W-1:0] jump_threshold;
		logic [CFG_W-1:0] cry_ratio;
		logic [CFG_W-1:0] voice_rms_low;
		logic [CFG_W-1:0] voice_rms_high;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/audio_window_sound_classifier.sv */
// A window's result word is formed after its last sample by the bit-serial
// divider and the 16-step square root in the back end.
// Throughput: one sample per cycle while the two-entry record queue is not full;
// the back end works on one window at a time, and the queue absorbs short windows.
// Reset clears the window sums, the queue and the output; registers take defaults.
// ----------------------------------------------------------------------------
// Audio window sound classifier
// Accumulates energy statistics of a sample window and reports RMS, peak
// change and the crying, screaming and voice-activity decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_window_sound_classifier #(
	parameter  int MAX_SAMPLES = 1024,
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
	localparam int SQ_W  = 30 + CNT_W,
	localparam int JE_W  = 32 + CNT_W,
	localparam int REC_W = SQ_W + JE_W + awsc_pkg::SAMPLE_W + CNT_W + 1,
	localparam int OUT_W = ((58 + CNT_W + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Sample stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [awsc_pkg::SAMPLE_W-1:0] s_tdata,  // [15:0] sample
	input  wire logic                          s_tlast,  // last sample of the window
	// Result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// From bit 0 up: rms_level(16), peak_change(23), crying(1), screaming(1),
	// voice_activity(16), sample_count(CNT_W), window_overflow(1), zero padding
	output logic      [OUT_W-1:0]              m_tdata,
	// Configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [awsc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);

	awsc_pkg::cfg_t    cfg;
	logic              q_full;
	logic              q_empty;
	logic              q_push;
	logic              q_pop;
	logic [REC_W-1:0]  q_wrec;
	logic [REC_W-1:0]  q_rrec;

	// Threshold registers.
	awsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Per-sample accumulation.
	awsc_front #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (q_wrec)
	);

	// Finished window records.
	awsc_fifo #(
		.W (REC_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wrec),
		.pop    (q_pop),
		.rdata  (q_rrec),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Window-end arithmetic and classification.
	awsc_back #(
		.CNT_W (CNT_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_rec    (q_rrec),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

/* rtl/awsc_regs.sv */
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style slave holding the seven classifier thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module awsc_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [awsc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output awsc_pkg::cfg_t                   cfg
);

	awsc_pkg::cfg_t              cfg_q;
	logic                        wr_en;
	logic [awsc_pkg::IDX_W-1:0]  idx;
	logic [awsc_pkg::CFG_W-1:0]  wval;
	logic [awsc_pkg::CFG_W-1:0]  rval;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[awsc_pkg::ADDR_W-1:2];
	assign wval   = pwdata[awsc_pkg::CFG_W-1:0];
	assign cfg    = cfg_q;

	// Register writes in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cry_rms_low     <= awsc_pkg::RST_CRY_RMS_LOW;
			cfg_q.cry_rms_high    <= awsc_pkg::RST_CRY_RMS_HIGH;
			cfg_q.scream_rms_high <= awsc_pkg::RST_SCREAM_RMS_HIGH;
			cfg_q.jump_threshold  <= awsc_pkg::RST_JUMP_THRESHOLD;
			cfg_q.cry_ratio       <= awsc_pkg::RST_CRY_RATIO;
			cfg_q.voice_rms_low   <= awsc_pkg::RST_VOICE_RMS_LOW;
			cfg_q.voice_rms_high  <= awsc_pkg::RST_VOICE_RMS_HIGH;
		end else if (wr_en) begin
			unique case (idx)
				awsc_pkg::REG_CRY_RMS_LOW:     cfg_q.cry_rms_low     <= wval;
				awsc_pkg::REG_CRY_RMS_HIGH:    cfg_q.cry_rms_high    <= wval;
				awsc_pkg::REG_SCREAM_RMS_HIGH: cfg_q.scream_rms_high <= wval;
				awsc_pkg::REG_JUMP_THRESHOLD:  cfg_q.jump_threshold  <= wval;
				awsc_pkg::REG_CRY_RATIO:       cfg_q.cry_ratio       <= wval;
				awsc_pkg::REG_VOICE_RMS_LOW:   cfg_q.voice_rms_low   <= wval;
				awsc_pkg::REG_VOICE_RMS_HIGH:  cfg_q.voice_rms_high  <= wval;
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		unique case (idx)
			awsc_pkg::REG_CRY_RMS_LOW:     rval = cfg_q.cry_rms_low;
			awsc_pkg::REG_CRY_RMS_HIGH:    rval = cfg_q.cry_rms_high;
			awsc_pkg::REG_SCREAM_RMS_HIGH: rval = cfg_q.scream_rms_high;
			awsc_pkg::REG_JUMP_THRESHOLD:  rval = cfg_q.jump_threshold;
			awsc_pkg::REG_CRY_RATIO:       rval = cfg_q.cry_ratio;
			awsc_pkg::REG_VOICE_RMS_LOW:   rval = cfg_q.voice_rms_low;
			awsc_pkg::REG_VOICE_RMS_HIGH:  rval = cfg_q.voice_rms_high;
			default:                       rval = '0;
		endcase
	end

	assign prdata = {{(32-awsc_pkg::CFG_W){1'b0}}, rval};

endmodule

`default_nettype wire

/* rtl/awsc_front.sv */
// ----------------------------------------------------------------------------
// Window accumulator
// Takes one sample per cycle while the queue is not full, builds the window sums
// and hands a finished window record to the queue when the last sample arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module awsc_front #(
	parameter  int MAX_SAMPLES = 1024,
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
	localparam int SQ_W  = 30 + CNT_W,
	localparam int JE_W  = 32 + CNT_W,
	localparam int REC_W = SQ_W + JE_W + awsc_pkg::SAMPLE_W + CNT_W + 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire awsc_pkg::cfg_t                cfg,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [awsc_pkg::SAMPLE_W-1:0] s_tdata,  // sample
	input  wire logic                          s_tlast,  // last sample of the window
	input  wire logic                          q_full,
	output logic                               q_push,
	output logic      [REC_W-1:0]              q_rec
);

	logic [SQ_W-1:0]               sq_q, sq_nxt;
	logic [JE_W-1:0]               je_q, je_nxt;
	logic [awsc_pkg::SAMPLE_W-1:0] mj_q, mj_nxt;
	logic [awsc_pkg::SAMPLE_W-1:0] prev_q, prev_nxt;
	logic [CNT_W-1:0]              tally_q, tally_nxt;
	logic                          ovf_q, ovf_nxt;

	logic                          accept;
	logic                          full;
	logic signed [15:0]            smp;
	logic signed [31:0]            smp_sq;
	logic signed [16:0]            diff;
	logic [15:0]                   dmag;
	logic [31:0]                   dmag_sq;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && s_tlast;

	// Per-sample arithmetic: square of the sample and of the step to it.
	assign smp     = s_tdata;
	assign smp_sq  = smp * smp;
	assign diff    = {smp[15], smp} - {prev_q[15], prev_q};
	assign dmag    = diff[16] ? 16'(-diff) : diff[15:0];
	assign dmag_sq = dmag * dmag;
	assign full    = (tally_q == CNT_W'(MAX_SAMPLES));

	// Next window state; samples past the limit only mark the overflow.
	always_comb begin
		sq_nxt    = sq_q;
		je_nxt    = je_q;
		mj_nxt    = mj_q;
		prev_nxt  = prev_q;
		tally_nxt = tally_q;
		ovf_nxt   = ovf_q;
		if (full) begin
			ovf_nxt = 1'b1;
		end else begin
			sq_nxt    = sq_q + SQ_W'($unsigned(smp_sq));
			prev_nxt  = s_tdata;
			tally_nxt = tally_q + 1'b1;
			if (tally_q != '0) begin
				if (dmag > cfg.jump_threshold) begin
					je_nxt = je_q + JE_W'(dmag_sq);
				end
				if (dmag > mj_q) begin
					mj_nxt = dmag;
				end
			end
		end
	end

	assign q_rec = {ovf_nxt, tally_nxt, mj_nxt, je_nxt, sq_nxt};

	// Window registers; cleared once the window's record is queued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q    <= '0;
			je_q    <= '0;
			mj_q    <= '0;
			prev_q  <= '0;
			tally_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				sq_q    <= '0;
				je_q    <= '0;
				mj_q    <= '0;
				prev_q  <= '0;
				tally_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				sq_q    <= sq_nxt;
				je_q    <= je_nxt;
				mj_q    <= mj_nxt;
				prev_q  <= prev_nxt;
				tally_q <= tally_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/awsc_fifo.sv */
// ----------------------------------------------------------------------------
// Window record queue
// Two-entry queue between the accumulator and the classifier back end.
// ----------------------------------------------------------------------------
`default_nettype none

module awsc_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic      [W-1:0] rdata,
	output logic              full,
	output logic              empty
);

	logic [W-1:0] mem_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/awsc_back.sv */
// ----------------------------------------------------------------------------
// Window classifier back end
// Divides the square sum by the sample count, takes the integer square root,
// forms the energy-ratio test and the band decisions, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module awsc_back #(
	parameter  int CNT_W = 11,
	localparam int SQ_W  = 30 + CNT_W,
	localparam int JE_W  = 32 + CNT_W,
	localparam int REC_W = SQ_W + JE_W + awsc_pkg::SAMPLE_W + CNT_W + 1,
	localparam int RES_W = 58 + CNT_W,
	localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire awsc_pkg::cfg_t    cfg,
	input  wire logic [REC_W-1:0]  q_rec,
	input  wire logic              q_empty,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [OUT_W-1:0]  m_tdata
);

	localparam int NCH   = (SQ_W + 15) / 16;
	localparam int CH_W  = (NCH > 2) ? $clog2(NCH) : 1;
	localparam int PR_W  = SQ_W + 16;
	localparam int DC_W  = $clog2(SQ_W);
	localparam int MEAN_W = awsc_pkg::MEAN_W;
	localparam int RMS_W  = awsc_pkg::RMS_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                    state_q;

	// Window record under work.
	logic [SQ_W-1:0]               sq_q;
	logic [JE_W-1:0]               je_q;
	logic [awsc_pkg::SAMPLE_W-1:0] mj_q;
	logic [CNT_W-1:0]              tally_q;
	logic                          ovf_q;

	// Divider.
	logic [SQ_W-1:0]               dvd_q, dvd_nxt;
	logic [CNT_W-1:0]              rem_q;
	logic [CNT_W:0]                trial;
	logic                          qbit;
	logic [DC_W-1:0]               dcnt_q;

	// Square root.
	logic [MEAN_W-1:0]             v_q;
	logic [MEAN_W:0]               root_q;
	logic [MEAN_W-1:0]             bit_q;
	logic [MEAN_W:0]               rtry;

	// Ratio product, one 16-bit slice of the square sum per cycle.
	logic [NCH*16-1:0]             sq_pad;
	logic [15:0]                   chunk;
	logic [31:0]                   prod;
	logic [PR_W-1:0]               acc_q;
	logic [CH_W-1:0]               midx_q;
	logic                          mbusy_q;
	logic                          ratio_ok_q;

	// Result.
	logic [RMS_W-1:0]              rms;
	logic [awsc_pkg::PEAK_W-1:0]   peak;
	logic                          crying;
	logic                          screaming;
	logic [RMS_W-1:0]              voice;
	logic                          out_free;
	logic                          m_tvalid_q;
	logic [OUT_W-1:0]              m_tdata_q;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// One restoring divide step.
	assign trial   = {rem_q, dvd_q[SQ_W-1]};
	assign qbit    = (trial >= {1'b0, tally_q});
	assign dvd_nxt = {dvd_q[SQ_W-2:0], qbit};

	// One square-root digit.
	assign rtry = root_q + {1'b0, bit_q};

	// Slice product for the ratio test.
	assign sq_pad = (NCH*16)'(sq_q);
	assign chunk  = sq_pad[{midx_q, 4'b0000} +: 16];
	assign prod   = cfg.cry_ratio * chunk;

	// Band decisions on the finished RMS.
	assign rms       = root_q[RMS_W-1:0];
	assign peak      = awsc_pkg::PEAK_W'(mj_q) * awsc_pkg::PEAK_SCALE;
	assign crying    = (rms > cfg.cry_rms_low) && (rms < cfg.cry_rms_high) && ratio_ok_q;
	assign screaming = (rms > cfg.cry_rms_high) && (rms < cfg.scream_rms_high);

	always_comb begin
		voice = '0;
		if ((rms >= cfg.voice_rms_low) && (rms <= cfg.voice_rms_high)) begin
			if (rms[RMS_W-1:RMS_W-2] != 2'b00) begin
				voice = {1'b1, {(RMS_W-1){1'b0}}};
			end else begin
				voice = {rms[RMS_W-2:0], 1'b0};
			end
		end
	end

	// Datapath registers, loaded without reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					sq_q    <= q_rec[SQ_W-1:0];
					je_q    <= q_rec[SQ_W +: JE_W];
					mj_q    <= q_rec[SQ_W+JE_W +: awsc_pkg::SAMPLE_W];
					tally_q <= q_rec[SQ_W+JE_W+awsc_pkg::SAMPLE_W +: CNT_W];
					ovf_q   <= q_rec[REC_W-1];
					dvd_q   <= q_rec[SQ_W-1:0];
					rem_q   <= '0;
					acc_q   <= '0;
					midx_q  <= CH_W'(NCH - 1);
				end
			end
			ST_DIV: begin
				dvd_q <= dvd_nxt;
				rem_q <= qbit ? CNT_W'(trial - {1'b0, tally_q}) : trial[CNT_W-1:0];
				if (mbusy_q) begin
					acc_q  <= (acc_q << 16) + PR_W'(prod);
					midx_q <= midx_q - 1'b1;
				end
				if (dcnt_q == DC_W'(SQ_W - 1)) begin
					v_q    <= dvd_nxt[MEAN_W-1:0];
					root_q <= '0;
					bit_q  <= {1'b1, {(MEAN_W-1){1'b0}}};
				end
			end
			ST_SQRT: begin
				if (v_q >= rtry[MEAN_W-1:0] && !rtry[MEAN_W]) begin
					v_q    <= v_q - rtry[MEAN_W-1:0];
					root_q <= (root_q >> 1) + {1'b0, bit_q};
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q      <= bit_q >> 2;
				ratio_ok_q <= (sq_q != '0) && ({je_q, 15'b0} > acc_q);
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	// Sequencer and output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dcnt_q     <= '0;
			mbusy_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// The output word stays valid until the receiver takes it.
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_DIV;
						dcnt_q  <= '0;
						mbusy_q <= 1'b1;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (mbusy_q && midx_q == '0) begin
						mbusy_q <= 1'b0;
					end
					if (dcnt_q == DC_W'(SQ_W - 1)) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (bit_q[0]) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tdata_q  <= OUT_W'({ovf_q, tally_q, voice, screaming, crying,
							peak, rms});
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
